// ----- rtl/core/bst_pkg.sv -----
// Package with the types, codes and constants of the battery session tracker.
package bst_pkg;

  // Number of record words that a closed session sends out.
  localparam int RECORD_WORDS = 19;
  localparam int QUEUE_DEPTH = 2;
  // The charge word is the accumulator over 7200. It saturates from 7200 * 2^32 upward,
  // and below that it is (accumulator >> 5) / 225.
  localparam logic [63:0] CHARGE_SAT = 64'h0000_1C20_0000_0000;
  localparam logic [8:0]  CHARGE_DIV_ODD = 9'd225;
  localparam logic [47:0] SUM_MAX = 48'h7FFF_FFFF_FFFF;
  localparam logic [47:0] SUM_MIN = 48'h8000_0000_0000;

  // Configuration register indexes.
  localparam logic [1:0] CFG_DISCHARGE_THRESHOLD = 2'd0;
  localparam logic [1:0] CFG_TEMP_LIMIT = 2'd1;
  localparam logic [1:0] CFG_ENOUGH_SAMPLES = 2'd2;
  localparam logic [1:0] CFG_SOC_SWING = 2'd3;

  // Record word indexes.
  localparam logic [4:0] W_ID = 5'd0;
  localparam logic [4:0] W_TYPE = 5'd1;
  localparam logic [4:0] W_START_TIME = 5'd2;
  localparam logic [4:0] W_END_TIME = 5'd3;
  localparam logic [4:0] W_START_SOC = 5'd4;
  localparam logic [4:0] W_END_SOC = 5'd5;
  localparam logic [4:0] W_START_MV = 5'd6;
  localparam logic [4:0] W_END_MV = 5'd7;
  localparam logic [4:0] W_MIN_MV = 5'd8;
  localparam logic [4:0] W_MAX_MV = 5'd9;
  localparam logic [4:0] W_MIN_TEMP = 5'd10;
  localparam logic [4:0] W_MAX_TEMP = 5'd11;
  localparam logic [4:0] W_MIN_MA = 5'd12;
  localparam logic [4:0] W_MAX_MA = 5'd13;
  localparam logic [4:0] W_AVG_TEMP = 5'd14;
  localparam logic [4:0] W_AVG_MA = 5'd15;
  localparam logic [4:0] W_CHARGE = 5'd16;
  localparam logic [4:0] W_COUNT = 5'd17;
  localparam logic [4:0] W_FLAGS = 5'd18;

  // Quality flag bits.
  localparam int FLAG_GAUGE = 0;
  localparam int FLAG_TEMP = 2;
  localparam int FLAG_ENOUGH = 3;
  localparam int FLAG_SOC = 4;
  localparam logic [4:0] FLAGS_OPEN = 5'b00111;

  typedef enum logic [1:0] {
    SES_IDLE      = 2'd0,
    SES_CHARGE    = 2'd1,
    SES_DISCHARGE = 2'd2
  } ses_type_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_UPD_MUL,
    ST_UPD_ACC,
    ST_DIV_TEMP,
    ST_DIV_CUR,
    ST_EMIT,
    ST_OPEN,
    ST_STATUS
  } back_state_t;

  typedef struct packed {
    logic               action;
    logic [31:0]        time_ms;
    logic [6:0]         soc_pct;
    logic [15:0]        voltage_mv;
    logic signed [11:0] temperature_dc;
    logic signed [15:0] current_ma;
    logic               charging;
    logic               gauge_valid;
  } in_t;

  typedef struct packed {
    logic        is_record_word;
    logic [4:0]  word_index;
    logic [31:0] word_value;
    logic [1:0]  start_event;
    logic        charge_ended;
    logic        session_active;
    logic        last;
  } out_t;

  // An item in the queue together with the class the front gave it.
  typedef struct packed {
    in_t       item;
    ses_type_t cls;
  } q_item_t;

  // Configuration that the back part reads.
  typedef struct packed {
    logic signed [11:0] temp_limit_dc;
    logic [15:0]        enough_samples;
    logic [6:0]         soc_swing_pct;
  } cfg_t;

  // Request to the divider.
  typedef struct packed {
    logic        start;
    logic [63:0] dividend;
    logic [31:0] divisor;
  } div_req_t;

endpackage

// ----- rtl/core/bst_front.sv -----
// Front part: configuration registers, sample classification and the item queue.
module bst_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [1:0]       cfg_index,
  input  logic [15:0]      cfg_data,
  input  logic             in_valid,
  output logic             in_ready,
  input  bst_pkg::in_t     in_item,
  output logic             q_valid,
  output bst_pkg::q_item_t q_data,
  input  logic             q_pop,
  output bst_pkg::cfg_t    cfg
);

  logic signed [15:0] threshold;
  bst_pkg::q_item_t   slots [bst_pkg::QUEUE_DEPTH];
  logic               wr_ptr;
  logic               rd_ptr;
  logic [1:0]         fill;
  logic               push;
  bst_pkg::ses_type_t cls;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= -16'sd50;
      cfg.temp_limit_dc <= 12'sd450;
      cfg.enough_samples <= 16'd10;
      cfg.soc_swing_pct <= 7'd10;
    end else if (cfg_we) begin
      unique case (cfg_index)
        bst_pkg::CFG_DISCHARGE_THRESHOLD: threshold <= cfg_data;
        bst_pkg::CFG_TEMP_LIMIT: cfg.temp_limit_dc <= cfg_data[11:0];
        bst_pkg::CFG_ENOUGH_SAMPLES: cfg.enough_samples <= cfg_data;
        bst_pkg::CFG_SOC_SWING: cfg.soc_swing_pct <= cfg_data[6:0];
      endcase
    end
  end

  // Class of the incoming sample.
  always_comb begin
    if (in_item.charging) begin
      cls = bst_pkg::SES_CHARGE;
    end else if (in_item.current_ma < threshold) begin
      cls = bst_pkg::SES_DISCHARGE;
    end else begin
      cls = bst_pkg::SES_IDLE;
    end
  end

  assign in_ready = (fill != 2'(bst_pkg::QUEUE_DEPTH));
  assign push = in_valid && in_ready;
  assign q_valid = (fill != 2'd0);
  assign q_data = slots[rd_ptr];

  // Two-entry queue toward the back part.
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= '{item: in_item, cls: cls};
    end
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (q_pop) rd_ptr <= ~rd_ptr;
      fill <= fill + 2'(push) - 2'(q_pop);
    end
  end

endmodule

// ----- rtl/core/bst_div.sv -----
// Restoring divider, 64-bit dividend by 32-bit divisor, one quotient bit per cycle.
module bst_div (
  input  logic              clk,
  input  logic              rst,
  input  bst_pkg::div_req_t req,
  output logic              done,
  output logic [63:0]       quotient
);

  logic [31:0] divisor;
  logic [32:0] rem;
  logic [32:0] rem_sh;
  logic [6:0]  steps;
  logic        busy;

  assign rem_sh = {rem[31:0], quotient[63]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      steps <= 7'd0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        steps <= 7'd0;
      end else if (busy) begin
        steps <= steps + 7'd1;
        if (steps == 7'd63) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
    // One shift and conditional subtract per cycle.
    if (req.start) begin
      divisor <= req.divisor;
      rem <= 33'd0;
      quotient <= req.dividend;
    end else if (busy) begin
      if (rem_sh >= {1'b0, divisor}) begin
        rem <= rem_sh - {1'b0, divisor};
        quotient <= {quotient[62:0], 1'b1};
      end else begin
        rem <= rem_sh;
        quotient <= {quotient[62:0], 1'b0};
      end
    end
  end

endmodule

// ----- rtl/core/bst_back.sv -----
// Back part: session state, update and close sequencer, and the output register.
module bst_back (
  input  logic             clk,
  input  logic             rst,
  input  bst_pkg::cfg_t    cfg,
  input  logic             q_valid,
  input  bst_pkg::q_item_t q_data,
  output logic             q_pop,
  output logic             out_valid,
  input  logic             out_ready,
  output bst_pkg::out_t    out_item
);

  bst_pkg::back_state_t state, state_next;

  // Session state.
  logic               active;
  bst_pkg::ses_type_t ses_type;
  logic [31:0]        next_id;
  logic [31:0]        cur_id;
  logic [31:0]        t_start, t_end;
  logic [6:0]         soc_start, soc_end;
  logic [15:0]        mv_start, mv_end, mv_min, mv_max;
  logic signed [11:0] temp_min, temp_max;
  logic signed [15:0] ma_min, ma_max;
  logic signed [47:0] temp_sum, cur_sum;
  logic [31:0]        count;
  logic [63:0]        charge_acc;
  logic [31:0]        prev_time;
  logic signed [15:0] prev_ma;
  logic [4:0]         flags;

  // Item in work and its sequencing.
  bst_pkg::q_item_t   cur;
  logic               do_open;
  logic               ended;
  logic [1:0]         start_ev;
  logic [4:0]         widx;
  logic [48:0]        product;
  logic               t_grows;
  logic [31:0]        avg_temp, avg_cur, charge_word;

  // Charge word division by a constant.
  logic [39:0]        chg_num;
  logic [7:0]         chg_rem;
  logic [2:0]         chg_steps;
  logic               chg_sat;
  logic [7:0]         chg_rem_n;
  logic [7:0]         chg_qbits;
  logic [8:0]         chg_trial;

  // Combinational control.
  logic               take;
  logic               load_rec, load_status;
  logic               do_update, do_opening, close_done;
  logic               latch_item, start_close;
  logic               out_free;
  bst_pkg::div_req_t  dreq;
  logic               div_done;
  logic [63:0]        div_q;

  bst_div u_div (
    .clk      (clk),
    .rst      (rst),
    .req      (dreq),
    .done     (div_done),
    .quotient (div_q)
  );

  assign out_free = !out_valid || out_ready;

  // Magnitudes of the sums; half the count is added to them in the divider request, for rounding to nearest.
  logic [47:0] temp_mag, cur_mag;
  assign temp_mag = temp_sum[47] ? 48'(-temp_sum) : 48'(temp_sum);
  assign cur_mag = cur_sum[47] ? 48'(-cur_sum) : 48'(cur_sum);

  // Next state, divider requests and strobes.
  always_comb begin
    state_next = state;
    take = 1'b0;
    latch_item = 1'b0;
    start_close = 1'b0;
    load_rec = 1'b0;
    load_status = 1'b0;
    do_update = 1'b0;
    do_opening = 1'b0;
    close_done = 1'b0;
    dreq = '{start: 1'b0, dividend: 64'd0, divisor: count};
    unique case (state)
      bst_pkg::ST_IDLE: begin
        if (q_valid) begin
          take = 1'b1;
          latch_item = 1'b1;
          if (q_data.item.action) begin
            start_close = active;
            state_next = active ? bst_pkg::ST_DIV_TEMP : bst_pkg::ST_STATUS;
          end else if (!active || ses_type != q_data.cls) begin
            start_close = active;
            state_next = active ? bst_pkg::ST_DIV_TEMP : bst_pkg::ST_OPEN;
          end else begin
            state_next = bst_pkg::ST_UPD_MUL;
          end
          if (start_close) begin
            dreq.start = 1'b1;
            dreq.dividend = 64'({1'b0, temp_mag} + 49'(count[31:1]));
          end
        end
      end
      bst_pkg::ST_UPD_MUL: state_next = bst_pkg::ST_UPD_ACC;
      bst_pkg::ST_UPD_ACC: begin
        do_update = 1'b1;
        state_next = bst_pkg::ST_STATUS;
      end
      bst_pkg::ST_DIV_TEMP: begin
        if (div_done) begin
          dreq.start = 1'b1;
          dreq.dividend = 64'({1'b0, cur_mag} + 49'(count[31:1]));
          state_next = bst_pkg::ST_DIV_CUR;
        end
      end
      bst_pkg::ST_DIV_CUR: begin
        if (div_done) state_next = bst_pkg::ST_EMIT;
      end
      bst_pkg::ST_EMIT: begin
        if (out_free) begin
          load_rec = 1'b1;
          if (widx == 5'(bst_pkg::RECORD_WORDS - 1)) begin
            close_done = 1'b1;
            state_next = do_open ? bst_pkg::ST_OPEN : bst_pkg::ST_STATUS;
          end
        end
      end
      bst_pkg::ST_OPEN: begin
        do_opening = 1'b1;
        state_next = bst_pkg::ST_STATUS;
      end
      bst_pkg::ST_STATUS: begin
        if (out_free) begin
          load_status = 1'b1;
          state_next = bst_pkg::ST_IDLE;
        end
      end
      default: state_next = bst_pkg::ST_IDLE;
    endcase
  end

  assign q_pop = take;

  always_ff @(posedge clk) begin
    if (rst) state <= bst_pkg::ST_IDLE;
    else state <= state_next;
  end

  // Record word selection.
  logic [31:0] word;
  logic [6:0]  soc_gap;
  logic [4:0]  close_flags;
  always_comb begin
    soc_gap = (soc_start > soc_end) ? soc_start - soc_end : soc_end - soc_start;
    close_flags = flags;
    if (count > 32'(cfg.enough_samples)) close_flags[bst_pkg::FLAG_ENOUGH] = 1'b1;
    if (soc_gap >= cfg.soc_swing_pct) close_flags[bst_pkg::FLAG_SOC] = 1'b1;
    unique case (widx)
      bst_pkg::W_ID: word = cur_id;
      bst_pkg::W_TYPE: word = 32'(ses_type);
      bst_pkg::W_START_TIME: word = t_start;
      bst_pkg::W_END_TIME: word = t_end;
      bst_pkg::W_START_SOC: word = 32'(soc_start);
      bst_pkg::W_END_SOC: word = 32'(soc_end);
      bst_pkg::W_START_MV: word = 32'(mv_start);
      bst_pkg::W_END_MV: word = 32'(mv_end);
      bst_pkg::W_MIN_MV: word = 32'(mv_min);
      bst_pkg::W_MAX_MV: word = 32'(mv_max);
      bst_pkg::W_MIN_TEMP: word = {{20{temp_min[11]}}, temp_min};
      bst_pkg::W_MAX_TEMP: word = {{20{temp_max[11]}}, temp_max};
      bst_pkg::W_MIN_MA: word = {{16{ma_min[15]}}, ma_min};
      bst_pkg::W_MAX_MA: word = {{16{ma_max[15]}}, ma_max};
      bst_pkg::W_AVG_TEMP: word = avg_temp;
      bst_pkg::W_AVG_MA: word = avg_cur;
      bst_pkg::W_CHARGE: word = charge_word;
      bst_pkg::W_COUNT: word = count;
      bst_pkg::W_FLAGS: word = 32'(close_flags);
      default: word = 32'd0;
    endcase
  end

  // Charge word: eight long-division steps by 225 per cycle, started at the close start and done
  // well before the record words go out.
  always_comb begin
    chg_rem_n = chg_rem;
    chg_qbits = 8'd0;
    chg_trial = 9'd0;
    for (int b = 0; b < 8; b++) begin
      chg_trial = {chg_rem_n, chg_num[39 - b]};
      if (chg_trial >= bst_pkg::CHARGE_DIV_ODD) begin
        chg_rem_n = 8'(chg_trial - bst_pkg::CHARGE_DIV_ODD);
        chg_qbits[7 - b] = 1'b1;
      end else begin
        chg_rem_n = chg_trial[7:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      chg_steps <= 3'd0;
    end else if (start_close) begin
      chg_num <= charge_acc[44:5];
      chg_rem <= 8'd0;
      chg_sat <= (charge_acc >= bst_pkg::CHARGE_SAT);
      chg_steps <= 3'd5;
    end else if (chg_steps != 3'd0) begin
      chg_num <= {chg_num[31:0], chg_qbits};
      chg_rem <= chg_rem_n;
      chg_steps <= chg_steps - 3'd1;
    end
  end

  assign charge_word = chg_sat ? 32'hFFFF_FFFF : chg_num[31:0];

  // Update arithmetic for a sample of the running session.
  logic signed [16:0] pair_sum;
  logic [16:0]        pair_mag;
  logic [31:0]        dt;
  logic signed [48:0] tsum_w, csum_w;
  logic signed [47:0] tsum_n, csum_n;
  logic [64:0]        acc_w;
  logic signed [11:0] tmax_n;
  always_comb begin
    pair_sum = 17'(prev_ma) + 17'(cur.item.current_ma);
    pair_mag = pair_sum[16] ? 17'(-pair_sum) : 17'(pair_sum);
    dt = cur.item.time_ms - prev_time;
    tsum_w = 49'(temp_sum) + 49'(cur.item.temperature_dc);
    csum_w = 49'(cur_sum) + 49'(cur.item.current_ma);
    if (tsum_w > 49'(signed'(bst_pkg::SUM_MAX))) tsum_n = bst_pkg::SUM_MAX;
    else if (tsum_w < 49'(signed'(bst_pkg::SUM_MIN))) tsum_n = bst_pkg::SUM_MIN;
    else tsum_n = tsum_w[47:0];
    if (csum_w > 49'(signed'(bst_pkg::SUM_MAX))) csum_n = bst_pkg::SUM_MAX;
    else if (csum_w < 49'(signed'(bst_pkg::SUM_MIN))) csum_n = bst_pkg::SUM_MIN;
    else csum_n = csum_w[47:0];
    acc_w = {1'b0, charge_acc} + 65'(product);
    tmax_n = (cur.item.temperature_dc > temp_max) ? cur.item.temperature_dc : temp_max;
  end

  // Sequencer registers.
  always_ff @(posedge clk) begin
    if (latch_item) begin
      cur <= q_data;
      widx <= 5'd0;
      if (q_data.item.action) begin
        do_open <= 1'b0;
        start_ev <= 2'(bst_pkg::SES_IDLE);
      end else begin
        do_open <= 1'b1;
        // Only a sample that opens a session reports a start event.
        start_ev <= (!active || ses_type != q_data.cls) ? q_data.cls : bst_pkg::SES_IDLE;
      end
      ended <= active && (ses_type == bst_pkg::SES_CHARGE) &&
               (q_data.item.action || ses_type != q_data.cls);
    end
    if (state == bst_pkg::ST_UPD_MUL) begin
      product <= 49'(pair_mag) * 49'(dt);
      t_grows <= cur.item.time_ms > prev_time;
    end
    if (state == bst_pkg::ST_DIV_TEMP && div_done) begin
      avg_temp <= temp_sum[47] ? 32'(-div_q[31:0]) : div_q[31:0];
    end
    if (state == bst_pkg::ST_DIV_CUR && div_done) begin
      avg_cur <= cur_sum[47] ? 32'(-div_q[31:0]) : div_q[31:0];
    end
    if (load_rec) widx <= widx + 5'd1;
  end

  // Session state.
  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      ses_type <= bst_pkg::SES_IDLE;
      next_id <= 32'd1;
      cur_id <= 32'd0;
      t_start <= 32'd0;
      t_end <= 32'd0;
      soc_start <= 7'd0;
      soc_end <= 7'd0;
      mv_start <= 16'd0;
      mv_end <= 16'd0;
      mv_min <= 16'd0;
      mv_max <= 16'd0;
      temp_min <= 12'sd0;
      temp_max <= 12'sd0;
      ma_min <= 16'sd0;
      ma_max <= 16'sd0;
      temp_sum <= 48'sd0;
      cur_sum <= 48'sd0;
      count <= 32'd0;
      charge_acc <= 64'd0;
      prev_time <= 32'd0;
      prev_ma <= 16'sd0;
      flags <= 5'd0;
    end else begin
      // Update of a running session.
      if (do_update) begin
        t_end <= cur.item.time_ms;
        soc_end <= cur.item.soc_pct;
        mv_end <= cur.item.voltage_mv;
        if (cur.item.voltage_mv < mv_min) mv_min <= cur.item.voltage_mv;
        if (cur.item.voltage_mv > mv_max) mv_max <= cur.item.voltage_mv;
        if (cur.item.temperature_dc < temp_min) temp_min <= cur.item.temperature_dc;
        temp_max <= tmax_n;
        if (cur.item.current_ma < ma_min) ma_min <= cur.item.current_ma;
        if (cur.item.current_ma > ma_max) ma_max <= cur.item.current_ma;
        temp_sum <= tsum_n;
        cur_sum <= csum_n;
        if (count != 32'hFFFF_FFFF) count <= count + 32'd1;
        if (t_grows) charge_acc <= acc_w[64] ? 64'hFFFF_FFFF_FFFF_FFFF : acc_w[63:0];
        prev_time <= cur.item.time_ms;
        prev_ma <= cur.item.current_ma;
        flags <= flags & ~(5'(tmax_n > cfg.temp_limit_dc) << bst_pkg::FLAG_TEMP)
                       & ~(5'(!cur.item.gauge_valid) << bst_pkg::FLAG_GAUGE);
      end

      // Opening of a new session with the current sample.
      if (do_opening) begin
        active <= 1'b1;
        cur_id <= next_id;
        next_id <= next_id + 32'd1;
        ses_type <= cur.cls;
        t_start <= cur.item.time_ms;
        t_end <= cur.item.time_ms;
        soc_start <= cur.item.soc_pct;
        soc_end <= cur.item.soc_pct;
        mv_start <= cur.item.voltage_mv;
        mv_end <= cur.item.voltage_mv;
        mv_min <= cur.item.voltage_mv;
        mv_max <= cur.item.voltage_mv;
        temp_min <= cur.item.temperature_dc;
        temp_max <= cur.item.temperature_dc;
        ma_min <= cur.item.current_ma;
        ma_max <= cur.item.current_ma;
        temp_sum <= 48'(cur.item.temperature_dc);
        cur_sum <= 48'(cur.item.current_ma);
        count <= 32'd1;
        charge_acc <= 64'd0;
        prev_time <= cur.item.time_ms;
        prev_ma <= cur.item.current_ma;
        flags <= bst_pkg::FLAGS_OPEN &
                 ~(5'(cur.item.temperature_dc > cfg.temp_limit_dc) << bst_pkg::FLAG_TEMP);
      end

      if (close_done) active <= 1'b0;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (load_rec) begin
      out_item <= '{is_record_word: 1'b1, word_index: widx, word_value: word,
                    start_event: 2'd0, charge_ended: 1'b0, session_active: 1'b0,
                    last: 1'b0};
    end else if (load_status) begin
      out_item <= '{is_record_word: 1'b0, word_index: 5'd0, word_value: 32'd0,
                    start_event: start_ev, charge_ended: ended,
                    session_active: active, last: 1'b1};
    end
    if (rst) out_valid <= 1'b0;
    else if (load_rec || load_status) out_valid <= 1'b1;
    else if (out_ready) out_valid <= 1'b0;
  end

endmodule

// ----- rtl/core/battery_session_tracker_core.sv -----
// Top level of the battery session tracker: front classifier, item queue and back sequencer.
// The block sorts each gauge sample as charging, discharging or idle, tracks the running
// session and, when a session closes, sends out its 19 record words before the status
// result that every item ends with. A sample that updates the running session passes the
// multiply and accumulate states of the back part, and one that opens a session with none
// running passes the open state. An item that closes a session waits on the shared divider,
// which gives one quotient bit per cycle, for each of the two averages in turn, then sends
// out the record words; the charge word comes from a short division by a constant that runs
// beside the averages. Output stalls hold the record words and the status. The two-entry
// queue lets the front take items while the back part works or waits on the output.
module battery_session_tracker_core (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_we,
  input  logic [1:0]    cfg_index,
  input  logic [15:0]   cfg_data,
  input  logic          in_valid,
  output logic          in_ready,
  input  bst_pkg::in_t  in_item,
  output logic          out_valid,
  input  logic          out_ready,
  output bst_pkg::out_t out_item
);

  logic             q_valid;
  logic             q_pop;
  bst_pkg::q_item_t q_data;
  bst_pkg::cfg_t    cfg;

  bst_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .q_valid   (q_valid),
    .q_data    (q_data),
    .q_pop     (q_pop),
    .cfg       (cfg)
  );

  bst_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_valid   (q_valid),
    .q_data    (q_data),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

endmodule

// ----- tb/sv/testbench.sv -----
// Testbench for the battery session tracker: random and directed gauge items, checked per field.
`timescale 1ns / 1ps

module testbench;

  localparam int CYCLE_LIMIT = 400000;
  localparam int CLOSE_CYCLES = 300;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  bst_pkg::in_t in_item = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  bst_pkg::out_t out_item;

  battery_session_tracker_core uut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
    .out_valid(out_valid), .out_ready(out_ready), .out_item(out_item)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Configuration copy used by the predictor.
  logic signed [15:0] thr_ma;
  logic signed [11:0] tlim_dc;
  logic [15:0] min_count;
  logic [6:0] swing_pct;

  // Session state copy.
  logic open_flag;
  bst_pkg::ses_type_t kind;
  logic [31:0] next_id, cur_id;
  logic [31:0] t0, t1, prev_t;
  logic [6:0] soc0, soc1;
  logic [15:0] mv0, mv1, mv_lo, mv_hi;
  logic signed [11:0] tc_lo, tc_hi;
  logic signed [15:0] ma_lo, ma_hi, prev_ma;
  logic signed [47:0] tsum, isum;
  logic [31:0] count;
  logic [63:0] charge_acc;
  logic [4:0] flags;

  bst_pkg::out_t expected_q[$];
  bst_pkg::in_t pending_q[$];
  int mismatches = 0;
  int checked = 0;
  int closes = 0;
  int cycles = 0;
  bit quiet = 1'b0;

  function automatic logic signed [47:0] sum_clamp(logic signed [47:0] s, logic signed [15:0] v);
    logic signed [49:0] r;
    r = s + v;
    if (r > 50'sh7FFF_FFFF_FFFF) return 48'sh7FFF_FFFF_FFFF;
    if (r < -50'sh8000_0000_0000) return 48'sh8000_0000_0000;
    return r[47:0];
  endfunction

  function automatic logic [31:0] round_mean(logic signed [47:0] s, logic [31:0] n);
    logic [63:0] mag, q;
    if (n == 0) return 0;
    mag = s < 0 ? 64'(-s) : 64'(s);
    q = (mag + (n >> 1)) / n;
    if (s < 0) q = -q;
    return q[31:0];
  endfunction

  function automatic bst_pkg::out_t make_word(logic [4:0] idx, logic [31:0] val);
    bst_pkg::out_t o;
    o = '0;
    o.is_record_word = 1'b1;
    o.word_index = idx;
    o.word_value = val;
    return o;
  endfunction

  // Close the running session and queue its record; returns whether it was charging.
  function automatic logic close_record();
    logic [6:0] diff;
    logic [63:0] q;
    if (!open_flag) return 1'b0;
    open_flag = 1'b0;
    closes++;
    if (32'(count) > 32'(min_count)) flags[bst_pkg::FLAG_ENOUGH] = 1'b1;
    diff = soc0 > soc1 ? soc0 - soc1 : soc1 - soc0;
    if (diff >= swing_pct) flags[bst_pkg::FLAG_SOC] = 1'b1;
    q = charge_acc / 64'd7200;
    expected_q.push_back(make_word(bst_pkg::W_ID, cur_id));
    expected_q.push_back(make_word(bst_pkg::W_TYPE, 32'(kind)));
    expected_q.push_back(make_word(bst_pkg::W_START_TIME, t0));
    expected_q.push_back(make_word(bst_pkg::W_END_TIME, t1));
    expected_q.push_back(make_word(bst_pkg::W_START_SOC, 32'(soc0)));
    expected_q.push_back(make_word(bst_pkg::W_END_SOC, 32'(soc1)));
    expected_q.push_back(make_word(bst_pkg::W_START_MV, 32'(mv0)));
    expected_q.push_back(make_word(bst_pkg::W_END_MV, 32'(mv1)));
    expected_q.push_back(make_word(bst_pkg::W_MIN_MV, 32'(mv_lo)));
    expected_q.push_back(make_word(bst_pkg::W_MAX_MV, 32'(mv_hi)));
    expected_q.push_back(make_word(bst_pkg::W_MIN_TEMP, 32'(signed'(tc_lo))));
    expected_q.push_back(make_word(bst_pkg::W_MAX_TEMP, 32'(signed'(tc_hi))));
    expected_q.push_back(make_word(bst_pkg::W_MIN_MA, 32'(signed'(ma_lo))));
    expected_q.push_back(make_word(bst_pkg::W_MAX_MA, 32'(signed'(ma_hi))));
    expected_q.push_back(make_word(bst_pkg::W_AVG_TEMP, round_mean(tsum, count)));
    expected_q.push_back(make_word(bst_pkg::W_AVG_MA, round_mean(isum, count)));
    expected_q.push_back(make_word(bst_pkg::W_CHARGE,
                                   q > 64'hFFFF_FFFF ? 32'hFFFF_FFFF : q[31:0]));
    expected_q.push_back(make_word(bst_pkg::W_COUNT, count));
    expected_q.push_back(make_word(bst_pkg::W_FLAGS, 32'(flags)));
    return kind == bst_pkg::SES_CHARGE;
  endfunction

  // Predict the results of one accepted item.
  function automatic void predict_item(bst_pkg::in_t it);
    bst_pkg::out_t st;
    bst_pkg::ses_type_t cls;
    logic ended;
    logic signed [16:0] pair;
    logic [63:0] inc, mag;
    st = '0;
    st.last = 1'b1;
    ended = 1'b0;
    if (it.action) begin
      ended = close_record();
    end else begin
      cls = it.charging ? bst_pkg::SES_CHARGE :
            (it.current_ma < thr_ma ? bst_pkg::SES_DISCHARGE : bst_pkg::SES_IDLE);
      if (!open_flag || kind != cls) begin
        ended = close_record();
        cur_id = next_id;
        next_id = next_id + 1;
        kind = cls;
        t0 = it.time_ms; t1 = it.time_ms; prev_t = it.time_ms;
        soc0 = it.soc_pct; soc1 = it.soc_pct;
        mv0 = it.voltage_mv; mv1 = it.voltage_mv;
        mv_lo = it.voltage_mv; mv_hi = it.voltage_mv;
        tc_lo = it.temperature_dc; tc_hi = it.temperature_dc;
        ma_lo = it.current_ma; ma_hi = it.current_ma; prev_ma = it.current_ma;
        tsum = it.temperature_dc; isum = it.current_ma;
        count = 1;
        charge_acc = 0;
        flags = bst_pkg::FLAGS_OPEN;
        open_flag = 1'b1;
        st.start_event = cls;
      end else begin
        t1 = it.time_ms; soc1 = it.soc_pct; mv1 = it.voltage_mv;
        if (it.voltage_mv < mv_lo) mv_lo = it.voltage_mv;
        if (it.voltage_mv > mv_hi) mv_hi = it.voltage_mv;
        if (it.temperature_dc < tc_lo) tc_lo = it.temperature_dc;
        if (it.temperature_dc > tc_hi) tc_hi = it.temperature_dc;
        if (it.current_ma < ma_lo) ma_lo = it.current_ma;
        if (it.current_ma > ma_hi) ma_hi = it.current_ma;
        tsum = sum_clamp(tsum, 16'(it.temperature_dc));
        isum = sum_clamp(isum, it.current_ma);
        if (count != 32'hFFFF_FFFF) count++;
        if (it.time_ms > prev_t) begin
          pair = 17'(prev_ma) + 17'(it.current_ma);
          mag = pair < 0 ? 64'(-pair) : 64'(pair);
          inc = mag * 64'(it.time_ms - prev_t);
          charge_acc = (charge_acc > ~inc) ? 64'hFFFF_FFFF_FFFF_FFFF : charge_acc + inc;
        end
        prev_t = it.time_ms;
        prev_ma = it.current_ma;
        if (!it.gauge_valid) flags[bst_pkg::FLAG_GAUGE] = 1'b0;
      end
      if (tc_hi > tlim_dc) flags[bst_pkg::FLAG_TEMP] = 1'b0;
    end
    st.charge_ended = ended;
    st.session_active = open_flag;
    expected_q.push_back(st);
  endfunction

  // Driver: presents pending items with random idle bursts.
  int in_gap = 0;
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) predict_item(in_item);
      if (!in_valid || in_ready) begin
        if (in_gap > 0) begin
          in_gap <= in_gap - 1;
          in_valid <= 1'b0;
        end else if (pending_q.size() > 0) begin
          in_item <= pending_q.pop_front();
          in_valid <= 1'b1;
          if (!quiet && $urandom_range(0, 5) == 0) in_gap <= $urandom_range(1, 5);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: random stalls on the output, field by field check.
  int out_gap = 0;
  always @(posedge clk) begin
    bst_pkg::out_t e;
    if (!rst) begin
      if (out_valid && out_ready) begin
        checked++;
        if (expected_q.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result, expected none actual %h", $time, out_item);
        end else begin
          e = expected_q.pop_front();
          if (e.is_record_word !== out_item.is_record_word)
            $display("%0t: is_record_word expected %0d actual %0d", $time,
                     e.is_record_word, out_item.is_record_word);
          if (e.word_index !== out_item.word_index)
            $display("%0t: word_index expected %0d actual %0d", $time,
                     e.word_index, out_item.word_index);
          if (e.word_value !== out_item.word_value)
            $display("%0t: word_value (index %0d) expected %h actual %h", $time,
                     e.word_index, e.word_value, out_item.word_value);
          if (e.start_event !== out_item.start_event)
            $display("%0t: start_event expected %0d actual %0d", $time,
                     e.start_event, out_item.start_event);
          if (e.charge_ended !== out_item.charge_ended)
            $display("%0t: charge_ended expected %0d actual %0d", $time,
                     e.charge_ended, out_item.charge_ended);
          if (e.session_active !== out_item.session_active)
            $display("%0t: session_active expected %0d actual %0d", $time,
                     e.session_active, out_item.session_active);
          if (e.last !== out_item.last)
            $display("%0t: last expected %0d actual %0d", $time, e.last, out_item.last);
          if (e !== out_item) mismatches++;
        end
      end
      if (out_gap > 0) begin
        out_gap <= out_gap - 1;
        out_ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 6) == 0) begin
        out_gap <= $urandom_range(0, 4);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Cycle limit.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Build one item with the given fields.
  function automatic bst_pkg::in_t make_item(logic act, logic [31:0] ts, logic [6:0] soc,
                                             logic [15:0] mv, logic signed [11:0] tdc,
                                             logic signed [15:0] ma, logic chg, logic gok);
    bst_pkg::in_t it;
    it.action = act; it.time_ms = ts; it.soc_pct = soc; it.voltage_mv = mv;
    it.temperature_dc = tdc; it.current_ma = ma; it.charging = chg; it.gauge_valid = gok;
    return it;
  endfunction

  // Random sample that is usually near the last one so that sessions run on.
  logic [31:0] clock_ms = 0;
  function automatic bst_pkg::in_t random_sample(int mode);
    logic signed [15:0] ma;
    logic [31:0] step;
    case ($urandom_range(0, 9))
      0: step = 0;
      1: step = $urandom;
      2: step = -$urandom_range(1, 1000);
      default: step = $urandom_range(1, 60000);
    endcase
    clock_ms = clock_ms + step;
    if ($urandom_range(0, 7) == 0) ma = 16'($urandom);
    else if (mode == 1) ma = 16'($urandom_range(0, 3000));
    else if (mode == 2) ma = 16'(-$urandom_range(60, 3000));
    else ma = 16'($urandom_range(0, 80) - 40);
    return make_item($urandom_range(0, 40) == 0, clock_ms, 7'($urandom_range(0, 100)),
                     16'($urandom), 12'($urandom_range(0, 1650) - 400), ma,
                     mode == 1 ? ($urandom_range(0, 9) != 0) : ($urandom_range(0, 12) == 0),
                     $urandom_range(0, 9) != 0);
  endfunction

  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    @(posedge clk);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      bst_pkg::CFG_DISCHARGE_THRESHOLD: thr_ma = val;
      bst_pkg::CFG_TEMP_LIMIT: tlim_dc = val[11:0];
      bst_pkg::CFG_ENOUGH_SAMPLES: min_count = val;
      default: swing_pct = val[6:0];
    endcase
  endtask

  // Wait until every item has left, sampled after the clock edge has settled.
  task automatic drain();
    while (pending_q.size() > 0 || in_valid || expected_q.size() > 0) @(negedge clk);
    repeat (CLOSE_CYCLES) @(posedge clk);
  endtask

  initial begin
    int mode;
    thr_ma = -50; tlim_dc = 450; min_count = 10; swing_pct = 10;
    open_flag = 0; kind = bst_pkg::SES_IDLE; next_id = 1; cur_id = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed: end with no session, extremes, each class, no time step, end action.
    pending_q.push_back(make_item(1, 32'hFFFF_FFFF, 127, 16'hFFFF, -1, -1, 1, 1));
    pending_q.push_back(make_item(0, 0, 0, 0, -400, -32768, 0, 1));
    pending_q.push_back(make_item(0, 32'hFFFF_FFFF, 100, 16'hFFFF, 1250, -32768, 0, 0));
    pending_q.push_back(make_item(0, 32'hFFFF_FFFF, 50, 3700, 200, -32768, 0, 1));
    pending_q.push_back(make_item(0, 100, 40, 3600, 250, 32767, 1, 1));
    pending_q.push_back(make_item(0, 3600100, 90, 4200, 300, 32767, 1, 1));
    pending_q.push_back(make_item(0, 3600100, 95, 4100, 460, 1000, 1, 0));
    pending_q.push_back(make_item(0, 3700000, 95, 4100, 200, -50, 0, 1));
    pending_q.push_back(make_item(0, 3800000, 94, 4090, 200, -51, 0, 1));
    pending_q.push_back(make_item(0, 3900000, 93, 4080, -400, -2000, 0, 1));
    pending_q.push_back(make_item(1, 3950000, 0, 0, 0, 0, 0, 0));
    pending_q.push_back(make_item(0, 4000000, 93, 4080, 100, 0, 0, 1));
    pending_q.push_back(make_item(0, 4100000, 93, 4080, 100, 20, 0, 1));
    pending_q.push_back(make_item(0, 4200000, 80, 4000, 500, 500, 1, 1));
    pending_q.push_back(make_item(1, 4300000, 0, 0, 0, 0, 1, 1));
    drain();

    // Random phases under several settings, extremes among them.
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        1: begin
          write_reg(bst_pkg::CFG_DISCHARGE_THRESHOLD, 16'h8000);
          write_reg(bst_pkg::CFG_TEMP_LIMIT, 16'h0E70);
          write_reg(bst_pkg::CFG_ENOUGH_SAMPLES, 16'd0);
          write_reg(bst_pkg::CFG_SOC_SWING, 16'd0);
        end
        2: begin
          write_reg(bst_pkg::CFG_DISCHARGE_THRESHOLD, 16'd0);
          write_reg(bst_pkg::CFG_TEMP_LIMIT, 16'd1250);
          write_reg(bst_pkg::CFG_ENOUGH_SAMPLES, 16'hFFFF);
          write_reg(bst_pkg::CFG_SOC_SWING, 16'd100);
        end
        3: begin
          write_reg(bst_pkg::CFG_DISCHARGE_THRESHOLD, 16'(-$urandom_range(0, 500)));
          write_reg(bst_pkg::CFG_TEMP_LIMIT, 16'($urandom_range(0, 800)));
          write_reg(bst_pkg::CFG_ENOUGH_SAMPLES, 16'($urandom_range(0, 20)));
          write_reg(bst_pkg::CFG_SOC_SWING, 16'($urandom_range(0, 30)));
        end
        4: begin
          write_reg(bst_pkg::CFG_DISCHARGE_THRESHOLD, 16'hFFCE);
          write_reg(bst_pkg::CFG_TEMP_LIMIT, 16'd450);
          write_reg(bst_pkg::CFG_ENOUGH_SAMPLES, 16'd10);
          write_reg(bst_pkg::CFG_SOC_SWING, 16'd10);
          quiet = 1'b1;
        end
        default: ;
      endcase
      mode = 0;
      for (int i = 0; i < 50; i++) begin
        if ($urandom_range(0, 9) == 0) mode = $urandom_range(0, 2);
        pending_q.push_back(random_sample(mode));
      end
      drain();
    end

    // Results that were predicted and never came out.
    if (expected_q.size() != 0) begin
      mismatches++;
      $display("%0t: results missing, expected %0d more actual 0", $time, expected_q.size());
    end
    $display("Checked %0d results, %0d closed session records, under five configurations.",
             checked, closes);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
